// File: rtl/assert_macros.svh
// assertion macros of the request line parser, included by hrlp_out_buf
// depends on a clk_i clock and an rst_ni active-low reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define HRLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define HRLP_ASSERT_NEXT(lbl, pre, post, msg) \
  `HRLP_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// File: rtl/hrlp_pkg.sv
// types, codes and tables of the http request line parser
// no dependencies
package hrlp_pkg;

  localparam int unsigned PosW = 16;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic [PosW-1:0] PosOne = PosW'(1);
  localparam logic [PosW-1:0] PosTwo = PosW'(2);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [15:0] position;
    logic [3:0]  method_code;
    logic [10:0] version_number;
    logic        irregular_uri;
    logic        quoted_uri;
    logic        plus_in_uri;
    logic        space_in_uri;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [2:0]      count;
    out_t [3:0]      item;
  } res_bundle_t;

  localparam logic [3:0] EvSchemaStart = 4'd0;
  localparam logic [3:0] EvSchemaEnd   = 4'd1;
  localparam logic [3:0] EvHostStart   = 4'd2;
  localparam logic [3:0] EvHostEnd     = 4'd3;
  localparam logic [3:0] EvPortEnd     = 4'd4;
  localparam logic [3:0] EvUriStart    = 4'd5;
  localparam logic [3:0] EvUriEnd      = 4'd6;
  localparam logic [3:0] EvArgsStart   = 4'd7;
  localparam logic [3:0] EvProtoStart  = 4'd8;
  localparam logic [3:0] EvDone        = 4'd9;
  localparam logic [3:0] EvError       = 4'd10;

  localparam logic [1:0] ErrMethod  = 2'd1;
  localparam logic [1:0] ErrRequest = 2'd2;
  localparam logic [1:0] ErrVersion = 2'd3;

  localparam logic [255:0] PlainMap = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'hffffffff, 32'hffffffff, 32'h7fff37d6, 32'hffffdbfe
  };

  // names right justified, first character in the highest used byte
  localparam logic [14:0][71:0] MethodName = '{
    72'("PROPPATCH"), 72'("PROPFIND"), 72'("OPTIONS"), 72'("UNLOCK"), 72'("DELETE"),
    72'("TRACE"), 72'("PATCH"), 72'("MKCOL"), 72'("HEAD"), 72'("LOCK"),
    72'("MOVE"), 72'("COPY"), 72'("POST"), 72'("PUT"), 72'("GET")
  };
  localparam logic [14:0][3:0] MethodLen = '{
    4'd9, 4'd8, 4'd7, 4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd3
  };

  // returns {hit, code}
  function automatic logic [4:0] method_match(input logic [8:0][7:0] chars,
                                              input logic [3:0] len);
    logic [4:0] r;
    logic       eq;
    logic [3:0] k;
    r = '0;
    for (int m = 14; m >= 0; m--) begin
      eq = (MethodLen[m] == len);
      for (int i = 0; i < 9; i++) begin
        k = 4'(i);
        if (k < len && chars[i] != MethodName[m][8*(len-k-4'd1) +: 8]) eq = 1'b0;
      end
      if (eq) r = {1'b1, 4'(m)};
    end
    return r;
  endfunction

endpackage

// File: rtl/http_request_line_parser.sv
// top level of the http request line parser: byte input channel, result output channel
// depends on hrlp_pkg, hrlp_parse_core and hrlp_out_buf
//
// usage: feed one request byte per request on in_data_i (data_byte, restart);
// set restart on the first byte of a new request to clear the parse state.
// each byte gives zero to four results, sent one per request on out_data_o;
// last_of_run marks the final result of a byte.
// results of a byte are registered and appear in the cycle after it is taken.
// throughput: one byte per cycle while each byte gives at most one result, taken
// at once; more results hold the input until the single result register drains.
// reset clears the parse state and drops pending results; no clearing pass.
// when the receiver stalls, the result register holds and input is refused
// until its last pending result is taken (a new byte is taken in that same cycle).
module http_request_line_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hrlp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrlp_pkg::out_t out_data_o
);

  hrlp_pkg::res_bundle_t res;
  logic                  fire;

  assign fire = in_valid_i && in_ready_o;

  hrlp_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_data_i),
    .res_o  (res)
  );

  hrlp_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/hrlp_parse_core.sv
// parse state and per-byte transition logic of the request line parser
// depends on hrlp_pkg
module hrlp_parse_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  hrlp_pkg::in_t        req_i,
  output hrlp_pkg::res_bundle_t res_o
);

  localparam logic [4:0] PhSkip = 5'd0, PhMethod = 5'd1, PhBeforeUri = 5'd2, PhSchema = 5'd3,
    PhSchemaSl = 5'd4, PhSchemaSl2 = 5'd5, PhHostStart = 5'd6, PhHost = 5'd7, PhHostEnd = 5'd8,
    PhIplit = 5'd9, PhPort = 5'd10, PhHost09 = 5'd11, PhAfterSlash = 5'd12, PhCheckUri = 5'd13,
    PhCheckUri09 = 5'd14, PhUri = 5'd15, PhHttp09 = 5'd16, PhH = 5'd17, PhHt = 5'd18,
    PhHtt = 5'd19, PhHttp = 5'd20, PhMaj1 = 5'd21, PhMaj = 5'd22, PhMin1 = 5'd23,
    PhMin = 5'd24, PhSpAfter = 5'd25, PhAlmost = 5'd26, PhIdle = 5'd27;

  localparam logic [7:0] ChCr = 8'd13, ChLf = 8'd10;

  logic [4:0]                 phase_q, phase_d, s_phase, ph;
  logic [8:0][7:0]            mc_q;
  logic                       mc_we;
  logic [3:0]                 mlen_q, mlen_d, s_mlen;
  logic [3:0]                 mfound_q, mfound_d, s_mfound;
  logic [hrlp_pkg::PosW-1:0]  off_q, off_d, pos, pos1, pos2;
  logic                       major_q, major_d;
  logic [9:0]                 minor_q, minor_d;
  logic [3:0]                 flags_q, flags_d;
  logic [2:0]                 n;
  logic                       go;
  logic [7:0]                 c;
  logic                       letter, digit, hostch, plain;
  logic [4:0]                 mm;
  logic [10:0]                ver;
  hrlp_pkg::out_t [3:0]       items;

  function automatic hrlp_pkg::out_t mk(input logic [3:0] kind,
                                        input logic [hrlp_pkg::PosW-1:0] p,
                                        input logic [1:0] err);
    hrlp_pkg::out_t o;
    o = '0;
    o.event_kind = kind;
    o.position   = 16'(p);
    o.error_code = err;
    return o;
  endfunction

  assign c      = req_i.data_byte;
  assign letter = ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
  assign digit  = (c >= "0") && (c <= "9");
  assign hostch = letter || digit || c == "." || c == "-";
  assign plain  = hrlp_pkg::PlainMap[c];

  assign s_phase  = req_i.restart ? PhSkip : phase_q;
  assign s_mlen   = req_i.restart ? 4'd0 : mlen_q;
  assign s_mfound = req_i.restart ? 4'd0 : mfound_q;
  assign pos      = req_i.restart ? '0 : off_q;
  assign pos1     = (pos == hrlp_pkg::PosMax) ? hrlp_pkg::PosMax : pos + hrlp_pkg::PosOne;
  assign pos2     = (pos >= hrlp_pkg::PosMax - hrlp_pkg::PosOne) ? hrlp_pkg::PosMax :
                    pos + hrlp_pkg::PosTwo;
  assign off_d    = pos1;
  assign mm       = hrlp_pkg::method_match(mc_q, s_mlen);
  assign ver      = {1'b0, minor_d} + (major_d ? 11'd1000 : 11'd0);

  always_comb begin
    phase_d  = s_phase;
    mlen_d   = s_mlen;
    mfound_d = s_mfound;
    major_d  = req_i.restart ? 1'b0 : major_q;
    minor_d  = req_i.restart ? 10'd0 : minor_q;
    flags_d  = req_i.restart ? 4'd0 : flags_q;
    mc_we    = 1'b0;
    n        = '0;
    items    = '0;
    go       = 1'b1;
    ph       = s_phase;

    if (ph == PhHostStart) begin
      items[n[1:0]] = mk(hrlp_pkg::EvHostStart, pos, 2'd0); n = n + 3'd1;
      if (c == "[") begin
        phase_d = PhIplit; go = 1'b0;
      end else begin
        ph = PhHost;
      end
    end
    if (go && ph == PhHost) begin
      if (hostch) begin
        phase_d = PhHost; go = 1'b0;
      end else begin
        ph = PhHostEnd;
      end
    end
    if (go && (ph == PhHost09 || ph == PhCheckUri09 || ph == PhHttp09)) begin
      go = 1'b0;
      if (c == " ") begin
        phase_d = ph;
      end else if (c == ChCr || c == ChLf) begin
        minor_d = 10'd9;
        phase_d = PhAlmost;
        if (c == ChLf) begin
          phase_d = PhIdle;
          if (ver == 11'd9 && s_mfound != 4'd0) begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrVersion);
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvDone, pos, 2'd0);
            items[n[1:0]].method_code    = s_mfound;
            items[n[1:0]].version_number = ver;
            {items[n[1:0]].space_in_uri, items[n[1:0]].plus_in_uri,
             items[n[1:0]].quoted_uri, items[n[1:0]].irregular_uri} = flags_d;
          end
          n = n + 3'd1;
        end
      end else if (c == "H") begin
        items[n[1:0]] = mk(hrlp_pkg::EvProtoStart, pos, 2'd0); n = n + 3'd1;
        phase_d = PhH;
      end else if (ph == PhHost09) begin
        items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
        phase_d = PhIdle;
      end else begin
        flags_d[3] = 1'b1;
        ph = (ph == PhHttp09) ? PhUri : PhCheckUri;
        phase_d = ph;
        go = 1'b1;
      end
    end

    if (go) begin
      unique case (ph)
        PhSkip: begin
          if (c == ChCr || c == ChLf) begin
            phase_d = PhSkip;
          end else if ((c >= "A" && c <= "Z") || c == "_" || c == "-") begin
            mc_we = 1'b1; mlen_d = 4'd1; phase_d = PhMethod;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrMethod); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhMethod: begin
          if (c == " ") begin
            if (!mm[4]) begin
              items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrMethod); n = n + 3'd1;
              phase_d = PhIdle;
            end else begin
              mfound_d = mm[3:0]; phase_d = PhBeforeUri;
            end
          end else if (s_mlen >= 4'd9) begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrMethod); n = n + 3'd1;
            phase_d = PhIdle;
          end else begin
            mc_we = 1'b1; mlen_d = s_mlen + 4'd1;
          end
        end
        PhBeforeUri: begin
          if (c == "/") begin
            items[n[1:0]] = mk(hrlp_pkg::EvUriStart, pos, 2'd0); n = n + 3'd1;
            phase_d = PhAfterSlash;
          end else if (letter) begin
            items[n[1:0]] = mk(hrlp_pkg::EvSchemaStart, pos, 2'd0); n = n + 3'd1;
            phase_d = PhSchema;
          end else if (c != " ") begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhSchema: begin
          if (letter || digit || c == "+" || c == "-" || c == ".") begin
            phase_d = PhSchema;
          end else if (c == ":") begin
            items[n[1:0]] = mk(hrlp_pkg::EvSchemaEnd, pos, 2'd0); n = n + 3'd1;
            phase_d = PhSchemaSl;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhSchemaSl, PhSchemaSl2: begin
          if (c == "/") begin
            phase_d = (ph == PhSchemaSl) ? PhSchemaSl2 : PhHostStart;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhHostEnd: begin
          items[n[1:0]] = mk(hrlp_pkg::EvHostEnd, pos, 2'd0); n = n + 3'd1;
          if (c == ":") begin
            phase_d = PhPort;
          end else if (c == "/") begin
            items[n[1:0]] = mk(hrlp_pkg::EvUriStart, pos, 2'd0); n = n + 3'd1;
            phase_d = PhAfterSlash;
          end else if (c == " ") begin
            items[n[1:0]] = mk(hrlp_pkg::EvUriStart, pos1, 2'd0); n = n + 3'd1;
            items[n[1:0]] = mk(hrlp_pkg::EvUriEnd, pos2, 2'd0); n = n + 3'd1;
            phase_d = PhHost09;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhIplit: begin
          if (digit || letter || c == ":" || c == "-" || c == "." || c == "_" || c == "~" ||
              c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
              c == "*" || c == "+" || c == "," || c == ";" || c == "=") begin
            phase_d = PhIplit;
          end else if (c == "]") begin
            phase_d = PhHostEnd;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhPort: begin
          if (digit) begin
            phase_d = PhPort;
          end else if (c == "/") begin
            items[n[1:0]] = mk(hrlp_pkg::EvPortEnd, pos, 2'd0); n = n + 3'd1;
            items[n[1:0]] = mk(hrlp_pkg::EvUriStart, pos, 2'd0); n = n + 3'd1;
            phase_d = PhAfterSlash;
          end else if (c == " ") begin
            items[n[1:0]] = mk(hrlp_pkg::EvPortEnd, pos, 2'd0); n = n + 3'd1;
            items[n[1:0]] = mk(hrlp_pkg::EvUriStart, pos1, 2'd0); n = n + 3'd1;
            items[n[1:0]] = mk(hrlp_pkg::EvUriEnd, pos2, 2'd0); n = n + 3'd1;
            phase_d = PhHost09;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhAfterSlash, PhCheckUri, PhUri: begin
          if (plain) begin
            phase_d = (ph == PhUri) ? PhUri : PhCheckUri;
          end else if (c == " " || c == ChCr || c == ChLf) begin
            items[n[1:0]] = mk(hrlp_pkg::EvUriEnd, pos, 2'd0); n = n + 3'd1;
            if (c == " ") begin
              phase_d = (ph == PhUri) ? PhHttp09 : PhCheckUri09;
            end else begin
              minor_d = 10'd9;
              phase_d = PhAlmost;
              if (c == ChLf) begin
                phase_d = PhIdle;
                if (ver == 11'd9 && s_mfound != 4'd0) begin
                  items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrVersion);
                end else begin
                  items[n[1:0]] = mk(hrlp_pkg::EvDone, pos, 2'd0);
                  items[n[1:0]].method_code    = s_mfound;
                  items[n[1:0]].version_number = ver;
                  {items[n[1:0]].space_in_uri, items[n[1:0]].plus_in_uri,
                   items[n[1:0]].quoted_uri, items[n[1:0]].irregular_uri} = flags_d;
                end
                n = n + 3'd1;
              end
            end
          end else if (ph == PhUri) begin
            if (c == "#") begin
              flags_d[0] = 1'b1;
            end else if (c == 8'd0) begin
              items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
              phase_d = PhIdle;
            end
          end else begin
            case (c)
              ".": begin
                if (ph == PhAfterSlash) begin
                  flags_d[0] = 1'b1; phase_d = PhUri;
                end
              end
              "/": begin
                if (ph == PhAfterSlash) begin
                  flags_d[0] = 1'b1; phase_d = PhUri;
                end else begin
                  phase_d = PhAfterSlash;
                end
              end
              "%": begin
                flags_d[1] = 1'b1; phase_d = PhUri;
              end
              "?": begin
                items[n[1:0]] = mk(hrlp_pkg::EvArgsStart, pos1, 2'd0); n = n + 3'd1;
                phase_d = PhUri;
              end
              "#": begin
                flags_d[0] = 1'b1; phase_d = PhUri;
              end
              "+": flags_d[2] = 1'b1;
              default: begin
                items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
                phase_d = PhIdle;
              end
            endcase
          end
        end
        PhH, PhHt, PhHtt, PhHttp: begin
          if ((ph == PhH && c == "T") || (ph == PhHt && c == "T") ||
              (ph == PhHtt && c == "P") || (ph == PhHttp && c == "/")) begin
            phase_d = ph + 5'd1;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhMaj1: begin
          if (c < "1" || c > "9") begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end else if (c > "1") begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrVersion); n = n + 3'd1;
            phase_d = PhIdle;
          end else begin
            major_d = 1'b1; phase_d = PhMaj;
          end
        end
        PhMaj: begin
          if (c == ".") begin
            phase_d = PhMin1;
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos,
                               digit ? hrlp_pkg::ErrVersion : hrlp_pkg::ErrRequest);
            n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        PhMin1: begin
          if (!digit) begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end else begin
            minor_d = {2'b00, c - 8'd48}; phase_d = PhMin;
          end
        end
        PhMin, PhSpAfter, PhAlmost: begin
          if (c == ChLf) begin
            phase_d = PhIdle;
            if (ver == 11'd9 && s_mfound != 4'd0) begin
              items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrVersion);
            end else begin
              items[n[1:0]] = mk(hrlp_pkg::EvDone, pos, 2'd0);
              items[n[1:0]].method_code    = s_mfound;
              items[n[1:0]].version_number = ver;
              {items[n[1:0]].space_in_uri, items[n[1:0]].plus_in_uri,
               items[n[1:0]].quoted_uri, items[n[1:0]].irregular_uri} = flags_d;
            end
            n = n + 3'd1;
          end else if (c == ChCr && ph != PhAlmost) begin
            phase_d = PhAlmost;
          end else if (c == " " && ph != PhAlmost) begin
            phase_d = PhSpAfter;
          end else if (ph == PhMin && digit && minor_d <= 10'd99) begin
            minor_d = 10'(minor_d * 10'd10) + {2'b00, c - 8'd48};
          end else begin
            items[n[1:0]] = mk(hrlp_pkg::EvError, pos, hrlp_pkg::ErrRequest); n = n + 3'd1;
            phase_d = PhIdle;
          end
        end
        default: phase_d = ph;
      endcase
    end
    if (n != 3'd0) items[2'(n - 3'd1)].last_of_run = 1'b1;
  end

  assign res_o.count = n;
  assign res_o.item  = items;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSkip;
      mlen_q   <= '0;
      mfound_q <= '0;
      off_q    <= '0;
      major_q  <= 1'b0;
      minor_q  <= '0;
      flags_q  <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      mlen_q   <= mlen_d;
      mfound_q <= mfound_d;
      off_q    <= off_d;
      major_q  <= major_d;
      minor_q  <= minor_d;
      flags_q  <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && mc_we) mc_q[s_mlen] <= c;
  end

endmodule

// File: rtl/hrlp_out_buf.sv
// result register holding up to four results of one byte, sent one per request
// depends on hrlp_pkg and assert_macros.svh
`include "assert_macros.svh"
module hrlp_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  hrlp_pkg::res_bundle_t res_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hrlp_pkg::out_t        out_data_o
);

  hrlp_pkg::out_t [3:0] item_q;
  logic [2:0]           cnt_q, cnt_d;
  logic [1:0]           idx_q, idx_d;
  logic                 fire, last;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = item_q[idx_q];
  assign fire        = out_valid_o && out_ready_i;
  assign last        = ({1'b0, idx_q} == cnt_q - 3'd1);
  assign space_o     = !out_valid_o || (fire && last);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (fire) begin
      if (last) cnt_d = 3'd0;
      else idx_d = idx_q + 2'd1;
    end
    if (load_i) begin
      cnt_d = res_i.count;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) item_q <= res_i.item;
  end

  `HRLP_ASSERT(a_idx_in_range, !out_valid_o || ({1'b0, idx_q} < cnt_q), "index past count")
  `HRLP_ASSERT(a_load_when_free, !load_i || space_o, "load over pending results")
  `HRLP_ASSERT(a_last_flag, !out_valid_o || (out_data_o.last_of_run == last), "last flag mismatch")
  `HRLP_ASSERT_NEXT(a_hold_on_stall, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(idx_q), "pending result dropped")

endmodule
